// ===== hdl/agsd_pkg.sv =====
// Shared constants and types for the ADC gain sideband deframer.
package agsd_pkg;

    localparam int unsigned MAX_RECORD_SAMPLES = 65536;
    localparam int unsigned IDX_W = $clog2(MAX_RECORD_SAMPLES);

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned SAMPLE_W = 14;
    localparam int unsigned HIST_W   = 16;
    localparam int unsigned GAIN_W   = 8;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned CNT_W    = 3;

    localparam logic [HIST_W-1:0] SYNC_PATTERN = 16'h00ff;
    localparam logic [CNT_W-1:0]  GAIN_PAIRS   = 3'd4;
    localparam logic [31:0]       POS_OFFSET   = 32'd7;
    localparam logic [IDX_W-1:0]  IDX_LAST     = IDX_W'(MAX_RECORD_SAMPLES - 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       gain_event;
        logic [GAIN_W-1:0]          gain_value;
        logic [POS_W-1:0]           gain_position;
    } t_result;

endpackage

// ===== hdl/agsd_if.sv =====
// Valid/ready channel interfaces for the deframer input and result streams.
interface agsd_in_if;
    logic                              valid;
    logic                              ready;
    logic [agsd_pkg::WORD_W-1:0]       adc_word;
    logic                              record_start;

    modport source (output valid, output adc_word, output record_start, input ready);
    modport sink   (input valid, input adc_word, input record_start, output ready);
endinterface

interface agsd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [agsd_pkg::SAMPLE_W-1:0] sample_value;
    logic                                gain_event;
    logic [agsd_pkg::GAIN_W-1:0]         gain_value;
    logic [agsd_pkg::POS_W-1:0]          gain_position;

    modport source (output valid, output sample_value, output gain_event,
                    output gain_value, output gain_position, input ready);
    modport sink   (input valid, input sample_value, input gain_event,
                    input gain_value, input gain_position, output ready);
endinterface

// ===== hdl/adc_gain_sideband_deframer.sv =====
// Top level of the ADC gain sideband deframer: handshake and result register.
//
// Usage:
//   i_in carries one raw 16-bit ADC word per transfer plus a record_start flag
//   that marks the first word of a record. o_out returns exactly one result per
//   input word: the signed 14-bit sample (Q1.13) from the low 14 bits and, when
//   a gain word completes with a first or changed value, a gain event with its
//   8-bit value and a record position (last gain word's index minus 7, modulo 2^16).
//   The result is registered: a word transferred at one edge shows its result on
//   o_out after that edge. Throughput is one word per cycle while o_out is not
//   stalled; the sideband state updates once per accepted word.
//   A single result register parts the two channels. i_in.ready is high while
//   that register is empty or being drained in the same cycle, so a stalled
//   receiver holds the result and stalls the source after one word.
//   Reset (synchronous, active low) empties the result register and clears the
//   sideband history, sync state, word index and last gain. record_start
//   clears the same state in-band, before its own word is handled.
module adc_gain_sideband_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    agsd_in_if.sink    i_in,
    agsd_out_if.source o_out
);

    logic              accept;
    logic              r_valid;
    agsd_pkg::t_result r_result;
    agsd_pkg::t_result core_result;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    agsd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_adc_word     (i_in.adc_word),
        .i_record_start (i_in.record_start),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset; load on every input transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= core_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.sample_value  = r_result.sample_value;
    assign o_out.gain_event    = r_result.gain_event;
    assign o_out.gain_value    = r_result.gain_value;
    assign o_out.gain_position = r_result.gain_position;

endmodule

// ===== hdl/agsd_core.sv =====
// Sideband history, sync detection and gain assembly for one ADC word.
module agsd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [agsd_pkg::WORD_W-1:0]   i_adc_word,
    input  logic                          i_record_start,
    output agsd_pkg::t_result             o_result
);

    logic [agsd_pkg::HIST_W-1:0] r_hist,  n_hist;
    logic                        r_sync,  n_sync;
    logic [agsd_pkg::CNT_W-1:0]  r_cnt,   n_cnt;
    logic [agsd_pkg::IDX_W-1:0]  r_idx,   n_idx;
    logic [agsd_pkg::GAIN_W-1:0] r_last,  n_last;
    logic                        r_have,  n_have;

    logic [agsd_pkg::HIST_W-1:0] hist0;
    logic                        sync0;
    logic [agsd_pkg::CNT_W-1:0]  cnt0;
    logic [agsd_pkg::IDX_W-1:0]  idx0;
    logic [agsd_pkg::GAIN_W-1:0] last0;
    logic                        have0;
    logic [agsd_pkg::GAIN_W-1:0] gain;
    logic [31:0]                 idx_ext;

    always_comb begin
        // a record start clears state before its own word is handled
        hist0 = i_record_start ? '0 : r_hist;
        sync0 = i_record_start ? 1'b0 : r_sync;
        cnt0  = i_record_start ? '0 : r_cnt;
        idx0  = i_record_start ? '0 : r_idx;
        last0 = i_record_start ? '0 : r_last;
        have0 = i_record_start ? 1'b0 : r_have;

        n_hist  = {hist0[agsd_pkg::HIST_W-3:0], i_adc_word[agsd_pkg::WORD_W-1 -: 2]};
        n_sync  = sync0;
        n_cnt   = cnt0;
        n_last  = last0;
        n_have  = have0;
        gain    = n_hist[agsd_pkg::GAIN_W-1:0];
        idx_ext = 32'(idx0);

        o_result.sample_value  = signed'(i_adc_word[agsd_pkg::SAMPLE_W-1:0]);
        o_result.gain_event    = 1'b0;
        o_result.gain_value    = '0;
        o_result.gain_position = '0;

        if (sync0) begin
            n_cnt = cnt0 + 3'd1;
            if (n_cnt == agsd_pkg::GAIN_PAIRS) begin
                if (!have0 || gain != last0) begin
                    o_result.gain_event    = 1'b1;
                    o_result.gain_value    = gain;
                    o_result.gain_position = agsd_pkg::POS_W'(idx_ext - agsd_pkg::POS_OFFSET);
                    n_last = gain;
                    n_have = 1'b1;
                end
                n_hist = '0;
                n_sync = 1'b0;
            end
        end

        if (n_hist == agsd_pkg::SYNC_PATTERN) begin
            n_sync = 1'b1;
            n_cnt  = '0;
            n_hist = '0;
        end

        n_idx = (idx0 == agsd_pkg::IDX_LAST) ? '0 : idx0 + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_sync <= 1'b0;
            r_cnt  <= '0;
            r_idx  <= '0;
            r_last <= '0;
            r_have <= 1'b0;
        end else if (i_en) begin
            r_hist <= n_hist;
            r_sync <= n_sync;
            r_cnt  <= n_cnt;
            r_idx  <= n_idx;
            r_last <= n_last;
            r_have <= n_have;
        end
    end

endmodule

// ===== hdl/agsd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module agsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_gain_event,
    input logic [agsd_pkg::GAIN_W-1:0]   i_gain_value,
    input logic [agsd_pkg::POS_W-1:0]    i_gain_position
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("input transfer produced no result");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while result register empty");

    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_gain_event) |-> (i_gain_value == '0 && i_gain_position == '0))
        else $error("gain fields nonzero without gain event");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind adc_gain_sideband_deframer agsd_checker u_agsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_gain_event    (o_out.gain_event),
    .i_gain_value    (o_out.gain_value),
    .i_gain_position (o_out.gain_position)
);
